// ===== hdl/pidsep_pkg.sv =====
// Shared types and constants of the PID unit with integral separation.
// Used by pidsep_core and by the top level pid_with_integral_separation_unit.
// No dependencies.
package pidsep_pkg;

    localparam int SP_W       = 16;
    localparam int GAIN_W     = 24;
    localparam int BAND_W     = 16;
    localparam int LIMIT_W    = 21;
    localparam int DRIVE_W    = 24;
    localparam int STAT_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int ERR_W      = 17;
    localparam int INT_W      = 22;
    localparam int ISUM_W     = INT_W + 1;
    localparam int SLOPE_W    = 26;
    localparam int DIFF_W     = ERR_W + 1;
    localparam int COEF_W     = 16;
    localparam int COEF_SH    = 16;
    localparam int FACC_W     = 44;
    localparam int FQ_W       = FACC_W - COEF_SH;
    localparam int TERM_W     = INT_W + 1;
    localparam int OACC_W     = 56;
    localparam int DQ_W       = OACC_W - 16;
    localparam int CNT_W      = 5;

    localparam logic [COEF_W-1:0] COEF_KEEP = 16'd45875;
    localparam logic [COEF_W-1:0] COEF_NEW  = 16'd19661;

    localparam logic signed [ERR_W-1:0] ERR_HI = {1'b0, {(ERR_W - 1){1'b1}}};
    localparam logic signed [ERR_W-1:0] ERR_LO = {1'b1, {(ERR_W - 1){1'b0}}};
    localparam logic signed [SLOPE_W-1:0] SLOPE_HI = {1'b0, {(SLOPE_W - 1){1'b1}}};
    localparam logic signed [SLOPE_W-1:0] SLOPE_LO = {1'b1, {(SLOPE_W - 1){1'b0}}};

    localparam logic [SP_W-1:0]    RST_SETPOINT = 16'd0;
    localparam logic [GAIN_W-1:0]  RST_KP       = 24'd98304;
    localparam logic [GAIN_W-1:0]  RST_KI       = 24'd655;
    localparam logic [GAIN_W-1:0]  RST_KD       = 24'd5734400;
    localparam logic [BAND_W-1:0]  RST_BAND     = 16'd1024;
    localparam logic [LIMIT_W-1:0] RST_LIMIT    = 21'd1024000;
    localparam logic [DRIVE_W-1:0] RST_OUT_MAX  = 24'd204800;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SETPOINT   = 3'd0,
        CFG_KP         = 3'd1,
        CFG_KI         = 3'd2,
        CFG_KD         = 3'd3,
        CFG_BAND       = 3'd4,
        CFG_LIMIT      = 3'd5,
        CFG_OUTPUT_MAX = 3'd6
    } cfg_idx_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_HIGH = 2'd1,
        STAT_LOW  = 2'd2
    } clamp_stat_t;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_ERR    = 8'b0000_0010,
        ST_INTEG  = 8'b0000_0100,
        ST_FILT   = 8'b0000_1000,
        ST_FROUND = 8'b0001_0000,
        ST_MUL    = 8'b0010_0000,
        ST_OROUND = 8'b0100_0000,
        ST_OUT    = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic [SP_W-1:0]    setpoint;
        logic [GAIN_W-1:0]  kp;
        logic [GAIN_W-1:0]  ki;
        logic [GAIN_W-1:0]  kd;
        logic [BAND_W-1:0]  band;
        logic [LIMIT_W-1:0] limit;
        logic [DRIVE_W-1:0] output_max;
    } cfg_t;

    typedef struct packed {
        logic idle;
        logic done;
    } core_flags_t;

    typedef struct packed {
        logic [DRIVE_W-1:0] drive;
        clamp_stat_t        status;
    } result_t;

endpackage

// ===== hdl/pidsep_core.sv =====
// Sequencer and bit-serial datapath of the PID unit: error, integral, filtered slope
// and the gain products, one gain or coefficient bit per cycle.
// Depends on pidsep_pkg.
module pidsep_core #(
    parameter int SAMPLE_WIDTH       = 16,
    parameter int GAIN_FRACTION_BITS = 14
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic signed [SAMPLE_WIDTH-1:0]   meas,
    input  pidsep_pkg::cfg_t                 cfg,
    input  logic                             res_free,
    output pidsep_pkg::core_flags_t          flags,
    output pidsep_pkg::result_t              res
);
    import pidsep_pkg::*;

    localparam int DIFF_IN_W = ((SAMPLE_WIDTH > SP_W) ? SAMPLE_WIDTH : SP_W) + 1;
    localparam int RND_SH    = GAIN_FRACTION_BITS + 8;

    state_t state_reg, state_next;

    logic signed [SAMPLE_WIDTH-1:0] meas_reg;
    logic signed [ERR_W-1:0]        err_reg, err_next;
    logic signed [ERR_W-1:0]        prev_reg, prev_next;
    logic signed [INT_W-1:0]        integral_reg, integral_next;
    logic signed [SLOPE_W-1:0]      slope_reg, slope_next;
    logic signed [DIFF_W-1:0]       diff_reg, diff_next;
    logic signed [FACC_W-1:0]       facc_reg, facc_next;
    logic signed [OACC_W-1:0]       oacc_reg, oacc_next;
    logic signed [DQ_W-1:0]         dfull_reg, dfull_next;
    logic [GAIN_W-1:0]              sra_reg, sra_next;
    logic [GAIN_W-1:0]              srb_reg, srb_next;
    logic [GAIN_W-1:0]              src_reg, src_next;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;

    logic signed [DIFF_IN_W-1:0]    raw_err;
    logic signed [ERR_W-1:0]        err_sat;
    logic [ERR_W-1:0]               err_mag;
    logic                           in_band;
    logic signed [ISUM_W-1:0]       isum;
    logic signed [ISUM_W-1:0]       lim_pos;
    logic signed [ISUM_W-1:0]       lim_neg;
    logic signed [INT_W-1:0]        isum_sat;
    logic signed [FACC_W-1:0]       f_add_a;
    logic signed [FACC_W-1:0]       f_add_b;
    logic signed [FACC_W-1:0]       f_rnd;
    logic signed [FQ_W-1:0]         f_q;
    logic signed [SLOPE_W-1:0]      f_sat;
    logic signed [TERM_W-1:0]       m_term;
    logic signed [OACC_W-1:0]       m_add_k;
    logic signed [OACC_W-1:0]       m_add_d;
    logic signed [OACC_W-1:0]       o_rnd;

    always_comb
    begin
        raw_err = DIFF_IN_W'(meas_reg) - DIFF_IN_W'($signed(cfg.setpoint));
        if (raw_err > DIFF_IN_W'(ERR_HI))
        begin
            err_sat = ERR_HI;
        end
        else if (raw_err < DIFF_IN_W'(ERR_LO))
        begin
            err_sat = ERR_LO;
        end
        else
        begin
            err_sat = ERR_W'(raw_err);
        end

        err_mag = err_reg[ERR_W-1] ? ERR_W'(-err_reg) : ERR_W'(err_reg);
        in_band = err_mag < {1'b0, cfg.band};
        isum    = ISUM_W'(integral_reg) + ISUM_W'(err_reg);
        lim_pos = $signed({{(ISUM_W - LIMIT_W){1'b0}}, cfg.limit});
        lim_neg = -lim_pos;
        if (isum > lim_pos)
        begin
            isum_sat = INT_W'(lim_pos);
        end
        else if (isum < lim_neg)
        begin
            isum_sat = INT_W'(lim_neg);
        end
        else
        begin
            isum_sat = INT_W'(isum);
        end

        f_add_a = sra_reg[GAIN_W-1] ? FACC_W'(slope_reg) : FACC_W'(0);
        f_add_b = srb_reg[GAIN_W-1] ? FACC_W'($signed({diff_reg, 8'h00})) : FACC_W'(0);
        f_rnd   = facc_reg + (FACC_W'(1) <<< (COEF_SH - 1));
        f_q     = FQ_W'(f_rnd >>> COEF_SH);
        if (f_q > FQ_W'(SLOPE_HI))
        begin
            f_sat = SLOPE_HI;
        end
        else if (f_q < FQ_W'(SLOPE_LO))
        begin
            f_sat = SLOPE_LO;
        end
        else
        begin
            f_sat = SLOPE_W'(f_q);
        end

        m_term  = (sra_reg[GAIN_W-1] ? TERM_W'(err_reg) : TERM_W'(0))
                + (srb_reg[GAIN_W-1] ? TERM_W'(integral_reg) : TERM_W'(0));
        m_add_k = OACC_W'($signed({m_term, 8'h00}));
        m_add_d = src_reg[GAIN_W-1] ? OACC_W'(slope_reg) : OACC_W'(0);
        o_rnd   = oacc_reg + (OACC_W'(1) <<< (RND_SH - 1));
    end

    always_comb
    begin
        state_next    = state_reg;
        err_next      = err_reg;
        prev_next     = prev_reg;
        integral_next = integral_reg;
        slope_next    = slope_reg;
        diff_next     = diff_reg;
        facc_next     = facc_reg;
        oacc_next     = oacc_reg;
        dfull_next    = dfull_reg;
        sra_next      = sra_reg;
        srb_next      = srb_reg;
        src_next      = src_reg;
        cnt_next      = cnt_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_ERR;
                end
            end
            ST_ERR:
            begin
                err_next   = err_sat;
                state_next = ST_INTEG;
            end
            ST_INTEG:
            begin
                integral_next = in_band ? isum_sat : INT_W'(0);
                diff_next     = DIFF_W'(err_reg) - DIFF_W'(prev_reg);
                prev_next     = err_reg;
                facc_next     = '0;
                sra_next      = {COEF_KEEP, {(GAIN_W - COEF_W){1'b0}}};
                srb_next      = {COEF_NEW, {(GAIN_W - COEF_W){1'b0}}};
                cnt_next      = CNT_W'(COEF_W - 1);
                state_next    = ST_FILT;
            end
            ST_FILT:
            begin
                facc_next = (facc_reg <<< 1) + f_add_a + f_add_b;
                sra_next  = sra_reg << 1;
                srb_next  = srb_reg << 1;
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_FROUND;
                end
            end
            ST_FROUND:
            begin
                slope_next = f_sat;
                oacc_next  = '0;
                sra_next   = cfg.kp;
                srb_next   = cfg.ki;
                src_next   = cfg.kd;
                cnt_next   = CNT_W'(GAIN_W - 1);
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                oacc_next = (oacc_reg <<< 1) + m_add_k + m_add_d;
                sra_next  = sra_reg << 1;
                srb_next  = srb_reg << 1;
                src_next  = src_reg << 1;
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_OROUND;
                end
            end
            ST_OROUND:
            begin
                dfull_next = DQ_W'(o_rnd >>> RND_SH);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (res_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (dfull_reg[DQ_W-1])
        begin
            res.drive  = '0;
            res.status = STAT_LOW;
        end
        else if (dfull_reg > DQ_W'(cfg.output_max))
        begin
            res.drive  = cfg.output_max;
            res.status = STAT_HIGH;
        end
        else
        begin
            res.drive  = DRIVE_W'(dfull_reg);
            res.status = STAT_OK;
        end
        flags.idle = (state_reg == ST_IDLE);
        flags.done = (state_reg == ST_OUT) && res_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            prev_reg     <= '0;
            integral_reg <= '0;
            slope_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            prev_reg     <= prev_next;
            integral_reg <= integral_next;
            slope_reg    <= slope_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && (state_reg == ST_IDLE))
        begin
            meas_reg <= meas;
        end
        err_reg   <= err_next;
        diff_reg  <= diff_next;
        facc_reg  <= facc_next;
        oacc_reg  <= oacc_next;
        dfull_reg <= dfull_next;
        sra_reg   <= sra_next;
        srb_reg   <= srb_next;
        src_reg   <= src_next;
        cnt_reg   <= cnt_next;
    end

endmodule

// ===== hdl/pid_with_integral_separation_unit.sv =====
// An item steps through ERR, INTEG, FILT, FROUND, MUL, OROUND and OUT to the output
// register. Items are taken only in IDLE; the pace is set by the 16-step serial filter
// and 24-step serial gain multiplies, which share one set of gain shift registers.
// A finished result waits in the output register while the next item is accepted.
// Reset clears the state (integral, slope, last error) and loads the default registers.
// Top level: stream ports, configuration registers and output register; uses pidsep_core.
module pid_with_integral_separation_unit #(
    parameter int SAMPLE_WIDTH       = 16,
    parameter int GAIN_FRACTION_BITS = 14
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // Fields from bit 0: measurement.
    input  logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // Fields from bit 0: drive.
    output logic [pidsep_pkg::DRIVE_W-1:0]           m_axis_tdata,
    // Fields from bit 0: clamp_status.
    output logic [pidsep_pkg::STAT_W-1:0]            m_axis_tuser,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [pidsep_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [pidsep_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import pidsep_pkg::*;

    cfg_t        cfg_reg;
    core_flags_t flags;
    result_t     res;
    logic        start;
    logic        res_free;
    logic        out_valid_reg;
    result_t     out_reg;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = flags.idle;
    assign start         = s_axis_tvalid && s_axis_tready;
    assign res_free      = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg.drive;
    assign m_axis_tuser  = out_reg.status;

    pidsep_core #(
        .SAMPLE_WIDTH       (SAMPLE_WIDTH),
        .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .meas     ($signed(s_axis_tdata[SAMPLE_WIDTH-1:0])),
        .cfg      (cfg_reg),
        .res_free (res_free),
        .flags    (flags),
        .res      (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.setpoint   <= RST_SETPOINT;
            cfg_reg.kp         <= RST_KP;
            cfg_reg.ki         <= RST_KI;
            cfg_reg.kd         <= RST_KD;
            cfg_reg.band       <= RST_BAND;
            cfg_reg.limit      <= RST_LIMIT;
            cfg_reg.output_max <= RST_OUT_MAX;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SETPOINT:   cfg_reg.setpoint   <= cfg_data[SP_W-1:0];
                CFG_KP:         cfg_reg.kp         <= cfg_data[GAIN_W-1:0];
                CFG_KI:         cfg_reg.ki         <= cfg_data[GAIN_W-1:0];
                CFG_KD:         cfg_reg.kd         <= cfg_data[GAIN_W-1:0];
                CFG_BAND:       cfg_reg.band       <= cfg_data[BAND_W-1:0];
                CFG_LIMIT:      cfg_reg.limit      <= cfg_data[LIMIT_W-1:0];
                CFG_OUTPUT_MAX: cfg_reg.output_max <= cfg_data[DRIVE_W-1:0];
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (flags.done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (flags.done)
        begin
            out_reg <= res;
        end
    end

endmodule
